// File: hdl/rule_set_sample_classifier_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the rule set sample classifier
// ----------------------------------------------------------------------------
`ifndef RULE_SET_SAMPLE_CLASSIFIER_MACROS_SVH
`define RULE_SET_SAMPLE_CLASSIFIER_MACROS_SVH

// implication checked on every clock edge outside reset
`define RSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsc check failed");

// next-cycle implication checked outside reset
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsc check failed");

`endif

// File: hdl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// types and constants shared by the rule set sample classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rsc_pkg;
	localparam int NUM_RULES      = 8;
	localparam int CONDS_PER_RULE = 4;
	localparam int SET_SIZE       = 4;
	localparam int NUM_FEATURES   = 256;

	localparam logic [1:0] OP_FEATURE    = 2'd0;
	localparam logic [1:0] OP_COND_HDR   = 2'd1;
	localparam logic [1:0] OP_COND_VALUE = 2'd2;
	localparam logic [1:0] OP_RULE_HDR   = 2'd3;

	localparam logic [1:0] KIND_AT_MOST  = 2'd0;
	localparam logic [1:0] KIND_AT_LEAST = 2'd1;
	localparam logic [1:0] KIND_RANGE    = 2'd2;
	localparam logic [1:0] KIND_SET      = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  rule_index;
		logic [1:0]  cond_slot;
		logic [1:0]  value_slot;
		logic [7:0]  feature_index;
		logic [1:0]  compare_kind;
		logic [2:0]  set_count;
		logic        enable;
		logic signed [31:0] value;
		logic        rule_class;
		logic        predict_is;
		logic        last_feature;
	} in_item_t;

	typedef struct packed {
		logic       covered;
		logic [2:0] first_rule;
		logic       pred_class;
	} out_item_t;

	// what a rule cell hands to its neighbor: token moving down the chain
	typedef struct packed {
		logic       found;
		logic [2:0] first_rule;
		logic       pred_class;
	} scan_t;

	// broadcast control from the top level into every rule cell
	typedef struct packed {
		logic       feat_valid;
		logic       last;
		logic       cond_wr;
		logic       val_wr;
		logic       rule_wr;
	} cell_ctl_t;
endpackage

// File: hdl/rsc_stream_if.sv
// ----------------------------------------------------------------------------
// rsc_stream_if
// valid/ready channel carrying one item type
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rsc_stream_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/rsc_rule_cell.sv
// ----------------------------------------------------------------------------
// rsc_rule_cell
// one rule: its conditions, met bits and a stage of the result scan chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rsc_rule_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         cell_idx,
	input  rsc_pkg::cell_ctl_t ctl,
	input  rsc_pkg::in_item_t  item,
	input  rsc_pkg::scan_t     scan_in,
	output rsc_pkg::scan_t     scan_out
);
	import rsc_pkg::*;

	logic [CONDS_PER_RULE-1:0] hvalid_q;
	logic [1:0]                kind_q  [CONDS_PER_RULE];
	logic [2:0]                count_q [CONDS_PER_RULE];
	logic [7:0]                feat_q  [CONDS_PER_RULE];
	logic [31:0]               val_q   [CONDS_PER_RULE][SET_SIZE];
	logic [CONDS_PER_RULE-1:0] met_q;
	logic                      en_q, cls_q, pred_q;
	logic [CONDS_PER_RULE-1:0] fail;
	logic [CONDS_PER_RULE-1:0] met_now;
	logic [CONDS_PER_RULE-1:0] met_next;
	logic                      covers;
	logic                      sel;
	logic [31:0]               x;

	assign sel = (item.rule_index == cell_idx);
	assign x   = item.value ^ 32'h8000_0000;

	always_comb begin
		for (int c = 0; c < CONDS_PER_RULE; c++) begin
			logic [31:0] b0, b1;
			logic        hit, ok;
			b0  = val_q[c][0] ^ 32'h8000_0000;
			b1  = val_q[c][1] ^ 32'h8000_0000;
			hit = 1'b0;
			for (int k = 0; k < SET_SIZE; k++)
				if (k < 32'(count_q[c]) && x == (val_q[c][k] ^ 32'h8000_0000))
					hit = 1'b1;
			case (kind_q[c])
				KIND_AT_MOST:  ok = (x <= b0);
				KIND_AT_LEAST: ok = (x >= b0);
				KIND_RANGE:    ok = (x >= b0) && (x <= b1);
				default:       ok = hit;
			endcase
			fail[c] = ctl.feat_valid && hvalid_q[c] && (feat_q[c] == item.feature_index) && !ok;
		end
	end

	assign met_now = met_q & ~fail;
	assign covers  = en_q && ((~hvalid_q | met_now) == '1);

	// met bits return to one at the end of a sample and on a header rewrite
	always_comb begin
		met_next = ctl.last ? '1 : met_now;
		if (ctl.cond_wr && sel)
			met_next[item.cond_slot] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
			met_q    <= '1;
			en_q     <= 1'b0;
		end else begin
			met_q <= met_next;
			if (ctl.cond_wr && sel)
				hvalid_q[item.cond_slot] <= item.enable;
			if (ctl.rule_wr && sel)
				en_q <= item.enable;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cond_wr && sel) begin
			kind_q[item.cond_slot]  <= item.compare_kind;
			count_q[item.cond_slot] <= (item.set_count > 3'(SET_SIZE)) ? 3'(SET_SIZE)
				: item.set_count;
			feat_q[item.cond_slot]  <= item.feature_index;
		end
		if (ctl.val_wr && sel)
			val_q[item.cond_slot][item.value_slot] <= item.value;
		if (ctl.rule_wr && sel) begin
			cls_q  <= item.rule_class;
			pred_q <= item.predict_is;
		end
	end

	// scan token: first covering rule wins, evaluated as the sample ends
	always_comb begin
		scan_out = scan_in;
		if (ctl.last && covers && !scan_in.found) begin
			scan_out.found      = 1'b1;
			scan_out.first_rule = cell_idx;
			scan_out.pred_class = pred_q ? cls_q : ~cls_q;
		end
	end
endmodule

// File: hdl/rule_set_sample_classifier.sv
// ----------------------------------------------------------------------------
// rule_set_sample_classifier
// streams sample features through a row of rule cells and reports coverage
// ----------------------------------------------------------------------------
// Takes one item per cycle, back to back: writes and sample features alike.
// Each rule lives in its own cell that compares the arriving feature against
// all of its conditions in that cycle; on the last feature the cells form a
// priority chain from rule 0 upward that picks the lowest covering rule. The
// result sits in one output register, so a sample's result appears the cycle
// after its last feature and the input keeps flowing while it waits, unless
// a second result would overwrite an untaken one. No clearing pass is needed
// after reset.
`timescale 1ns / 1ps
module rule_set_sample_classifier (
	input logic clk,
	input logic arst_n,
	rsc_stream_if.sink   in_ch,
	rsc_stream_if.source out_ch
);
	import rsc_pkg::*;

	in_item_t   item;
	logic       acc;
	cell_ctl_t  ctl;
	scan_t      chain [NUM_RULES+1];
	logic       out_valid_q;
	out_item_t  out_q;

	assign item = in_ch.payload;
	// stall only when a result waits and this item would produce another
	assign in_ch.ready = !out_valid_q || out_ch.ready || !(in_ch.payload.operation == OP_FEATURE
		&& in_ch.payload.last_feature);
	assign acc = in_ch.valid && in_ch.ready;

	always_comb begin
		ctl.feat_valid = acc && item.operation == OP_FEATURE;
		ctl.last       = acc && item.operation == OP_FEATURE && item.last_feature;
		ctl.cond_wr    = acc && item.operation == OP_COND_HDR;
		ctl.val_wr     = acc && item.operation == OP_COND_VALUE;
		ctl.rule_wr    = acc && item.operation == OP_RULE_HDR;
	end

	assign chain[0] = '0;

	// row of rule cells, lowest index has priority
	for (genvar r = 0; r < NUM_RULES; r++) begin : g_rule
		rsc_rule_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (3'(r)),
			.ctl      (ctl),
			.item     (item),
			.scan_in  (chain[r]),
			.scan_out (chain[r+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.last)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.last) begin
			out_q.covered    <= chain[NUM_RULES].found;
			out_q.first_rule <= chain[NUM_RULES].first_rule;
			out_q.pred_class <= chain[NUM_RULES].pred_class;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;
endmodule

// File: hdl/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker
// port level checks on the rule set sample classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rule_set_sample_classifier_macros.svh"
module rsc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [1:0] in_op,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_covered,
	input logic [2:0] out_first,
	input logic out_class
);
	import rsc_pkg::*;

	logic       last_acc;
	logic       uncovered;
	logic       zero_pick;
	logic       stalled;
	logic [4:0] out_word;

	assign last_acc  = in_valid && in_ready && in_op == OP_FEATURE && in_last;
	assign uncovered = out_valid && !out_covered;
	assign zero_pick = out_first == 3'd0 && !out_class;
	assign stalled   = out_valid && !out_ready;
	assign out_word  = {out_covered, out_first, out_class};

	`RSC_ASSERT_IMPL(a_uncovered_zero, clk, arst_n, uncovered, zero_pick)
	`RSC_ASSERT_NEXT(a_result_follows_last, clk, arst_n, last_acc, out_valid)
	`RSC_ASSERT_NEXT(a_no_spurious_result, clk, arst_n, !out_valid && !last_acc, !out_valid)
	`RSC_ASSERT_NEXT(a_out_holds, clk, arst_n, stalled, out_valid && $stable(out_word))
endmodule

bind rule_set_sample_classifier rsc_checker u_rsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_op       (in_ch.payload.operation),
	.in_last     (in_ch.payload.last_feature),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_covered (out_ch.payload.covered),
	.out_first   (out_ch.payload.first_rule),
	.out_class   (out_ch.payload.pred_class)
);
